// ----- sv/mxr_pkg.sv -----
package mxr_pkg;

  localparam int NUM_PORTS = 5;
  localparam int ROUTE_W   = 3;
  localparam int COORD_W   = 2;

  localparam int DEST_X_LO = 24;
  localparam int DEST_Y_LO = 22;

  localparam logic [ROUTE_W-1:0] PORT_N = 3'd0;
  localparam logic [ROUTE_W-1:0] PORT_W = 3'd1;
  localparam logic [ROUTE_W-1:0] PORT_S = 3'd2;
  localparam logic [ROUTE_W-1:0] PORT_E = 3'd3;
  localparam logic [ROUTE_W-1:0] PORT_L = 3'd4;

  localparam logic [ROUTE_W-1:0] ROUTE_NONE = 3'd0;

  localparam logic REG_NODE_X = 1'b0;
  localparam logic REG_NODE_Y = 1'b1;

  typedef struct packed {
    logic               nonempty;
    logic [ROUTE_W-1:0] route;
  } mxr_lane_stat_t;

  function automatic logic [ROUTE_W-1:0] route_of(
    input logic [COORD_W-1:0] dest_x,
    input logic [COORD_W-1:0] dest_y,
    input logic [COORD_W-1:0] node_x,
    input logic [COORD_W-1:0] node_y
  );
    logic [ROUTE_W-1:0] r;
    if (dest_x > node_x) begin
      r = PORT_E;
    end else if (dest_x < node_x) begin
      r = PORT_W;
    end else if (dest_y > node_y) begin
      r = PORT_S;
    end else if (dest_y < node_y) begin
      r = PORT_N;
    end else begin
      r = PORT_L;
    end
    return r;
  endfunction

endpackage

// ----- sv/mxr_lane.sv -----
module mxr_lane
  import mxr_pkg::*;
#(
  parameter int PORT_ID      = 0,
  parameter int BUFFER_DEPTH = 8,
  parameter int FLIT_WIDTH   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [COORD_W-1:0]    node_x,
  input  logic [COORD_W-1:0]    node_y,
  input  logic [FLIT_WIDTH-1:0] flit_in,
  input  logic                  arrive,
  input  logic                  own_ready,
  input  logic                  pop,
  output logic [FLIT_WIDTH-1:0] head,
  output mxr_lane_stat_t        stat,
  output logic                  uturn,
  output logic                  not_full
);

  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(BUFFER_DEPTH - 1);
  localparam logic [ROUTE_W-1:0] OWN_PORT = ROUTE_W'(PORT_ID);

  logic [FLIT_WIDTH-1:0] mem [BUFFER_DEPTH];
  logic [CW-1:0]      count_r, count_nxt, count_after_pop;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [ROUTE_W-1:0] held_route_r, held_route_nxt, r;
  logic               empty, push;

  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];
  assign r     = route_of(head[DEST_X_LO +: COORD_W], head[DEST_Y_LO +: COORD_W],
                          node_x, node_y);

  always_comb begin
    uturn          = 1'b0;
    held_route_nxt = held_route_r;
    if (own_ready) begin
      if (empty) begin
        held_route_nxt = ROUTE_NONE;
      end else if (r == OWN_PORT) begin
        uturn = 1'b1;
      end else begin
        held_route_nxt = r + 3'd1;
      end
    end
  end

  assign stat.nonempty = !empty;
  assign stat.route    = held_route_nxt;

  assign count_after_pop = count_r - {{(CW-1){1'b0}}, pop};
  assign push            = arrive && (count_after_pop < DEPTH_C);
  assign count_nxt       = count_after_pop + {{(CW-1){1'b0}}, push};
  assign not_full        = (count_nxt < DEPTH_C);

  assign rd_ptr_nxt = !pop ? rd_ptr_r : (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
  assign wr_ptr_nxt = !push ? wr_ptr_r : (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      held_route_r <= ROUTE_NONE;
    end else if (en) begin
      count_r      <= count_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      held_route_r <= held_route_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && push) begin
      mem[wr_ptr_r] <= flit_in;
    end
  end

endmodule

// ----- sv/mxr_xbar.sv -----
module mxr_xbar
  import mxr_pkg::*;
#(
  parameter int FLIT_WIDTH = 32
) (
  input  mxr_lane_stat_t [NUM_PORTS-1:0]                 stat,
  input  logic           [NUM_PORTS-1:0][FLIT_WIDTH-1:0] head,
  input  logic           [NUM_PORTS-1:0]                 ready,
  output logic           [NUM_PORTS-1:0][FLIT_WIDTH-1:0] send,
  output logic           [NUM_PORTS-1:0]                 send_valid,
  output logic           [NUM_PORTS-1:0]                 pop
);

  // Fixed priority: lowest input index wins; an input never holds a route to itself.
  always_comb begin
    send       = '0;
    send_valid = '0;
    pop        = '0;
    for (int q = 0; q < NUM_PORTS; q++) begin
      if (ready[q]) begin
        for (int s = 0; s < NUM_PORTS; s++) begin
          if (!send_valid[q] && stat[s].nonempty && stat[s].route == ROUTE_W'(q + 1)) begin
            send[q]       = head[s];
            send_valid[q] = 1'b1;
            pop[s]        = 1'b1;
          end
        end
      end
    end
  end

endmodule

// ----- sv/mesh_xy_router_five_port_unit.sv -----
// Results of an item appear on the out_ ports in the cycle after it is taken.
// Throughput: one item per cycle unless in_stall holds the input; route, crossbar
// arbitration and buffer update all complete together in the per-port lanes and the crossbar.
// Reset (rst_n low, synchronous): buffer counts, pointers, held routes, node
// coordinates and the output register are cleared; buffer storage is not.
module mesh_xy_router_five_port_unit
  import mxr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 8,
  parameter int FLIT_WIDTH   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [COORD_W-1:0]    cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FLIT_WIDTH-1:0] in_flit_north,
  input  logic [FLIT_WIDTH-1:0] in_flit_west,
  input  logic [FLIT_WIDTH-1:0] in_flit_south,
  input  logic [FLIT_WIDTH-1:0] in_flit_east,
  input  logic [FLIT_WIDTH-1:0] in_flit_local,
  input  logic [NUM_PORTS-1:0]  in_arrive_valid,
  input  logic [NUM_PORTS-1:0]  in_downstream_ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FLIT_WIDTH-1:0] out_send_north,
  output logic [FLIT_WIDTH-1:0] out_send_west,
  output logic [FLIT_WIDTH-1:0] out_send_south,
  output logic [FLIT_WIDTH-1:0] out_send_east,
  output logic [FLIT_WIDTH-1:0] out_send_local,
  output logic [NUM_PORTS-1:0]  out_send_valid,
  output logic [NUM_PORTS-1:0]  out_accept_ready,
  output logic [NUM_PORTS-1:0]  out_uturn_error
);

  logic [COORD_W-1:0] node_x_r, node_y_r;
  logic               out_valid_r;
  logic               acc;

  logic           [NUM_PORTS-1:0][FLIT_WIDTH-1:0] flit_in, head, send, send_r;
  mxr_lane_stat_t [NUM_PORTS-1:0]                 stat;
  logic           [NUM_PORTS-1:0] pop, uturn, not_full, send_valid;
  logic           [NUM_PORTS-1:0] send_valid_r, accept_ready_r, uturn_r;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  assign flit_in[PORT_N] = in_flit_north;
  assign flit_in[PORT_W] = in_flit_west;
  assign flit_in[PORT_S] = in_flit_south;
  assign flit_in[PORT_E] = in_flit_east;
  assign flit_in[PORT_L] = in_flit_local;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_x_r <= '0;
      node_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODE_X: node_x_r <= cfg_wdata;
        REG_NODE_Y: node_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  for (genvar p = 0; p < NUM_PORTS; p++) begin : g_lane
    mxr_lane #(
      .PORT_ID      (p),
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .FLIT_WIDTH   (FLIT_WIDTH)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (acc),
      .node_x    (node_x_r),
      .node_y    (node_y_r),
      .flit_in   (flit_in[p]),
      .arrive    (in_arrive_valid[p]),
      .own_ready (in_downstream_ready[p]),
      .pop       (pop[p]),
      .head      (head[p]),
      .stat      (stat[p]),
      .uturn     (uturn[p]),
      .not_full  (not_full[p])
    );
  end

  mxr_xbar #(
    .FLIT_WIDTH (FLIT_WIDTH)
  ) u_xbar (
    .stat       (stat),
    .head       (head),
    .ready      (in_downstream_ready),
    .send       (send),
    .send_valid (send_valid),
    .pop        (pop)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      send_r         <= '0;
      send_valid_r   <= '0;
      accept_ready_r <= '0;
      uturn_r        <= '0;
    end else begin
      if (acc) begin
        out_valid_r    <= 1'b1;
        send_r         <= send;
        send_valid_r   <= send_valid;
        accept_ready_r <= not_full;
        uturn_r        <= uturn;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_send_north   = send_r[PORT_N];
  assign out_send_west    = send_r[PORT_W];
  assign out_send_south   = send_r[PORT_S];
  assign out_send_east    = send_r[PORT_E];
  assign out_send_local   = send_r[PORT_L];
  assign out_send_valid   = send_valid_r;
  assign out_accept_ready = accept_ready_r;
  assign out_uturn_error  = uturn_r;

  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted item produced no result");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop & ~{stat[4].nonempty, stat[3].nonempty, stat[2].nonempty,
             stat[1].nonempty, stat[0].nonempty}) == '0)
    else $error("pop from empty buffer");

  a_send_matches_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(send_valid) == $countones(pop))
    else $error("send count differs from pop count");

  a_idle_north_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !send_valid_r[PORT_N] |-> send_r[PORT_N] == '0)
    else $error("idle north output carries data");

  a_idle_local_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !send_valid_r[PORT_L] |-> send_r[PORT_L] == '0)
    else $error("idle local output carries data");

endmodule

// ----- tb/sv/mesh_xy_router_five_port_unit_tb.sv -----
`timescale 1ns / 1ps

module mesh_xy_router_five_port_unit_tb;
  import mxr_pkg::*;

  localparam int FLIT_W         = 32;
  localparam int LANE_DEPTH     = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [NUM_PORTS-1:0][FLIT_W-1:0] flit;
    logic [NUM_PORTS-1:0]             arrive;
    logic [NUM_PORTS-1:0]             ready;
  } link_cycle_t;

  typedef struct packed {
    logic [NUM_PORTS-1:0][FLIT_W-1:0] send;
    logic [NUM_PORTS-1:0]             send_valid;
    logic [NUM_PORTS-1:0]             accept_ready;
    logic [NUM_PORTS-1:0]             uturn;
  } departure_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [COORD_W-1:0]    cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [FLIT_W-1:0]     in_flit_north;
  logic [FLIT_W-1:0]     in_flit_west;
  logic [FLIT_W-1:0]     in_flit_south;
  logic [FLIT_W-1:0]     in_flit_east;
  logic [FLIT_W-1:0]     in_flit_local;
  logic [NUM_PORTS-1:0]  in_arrive_valid;
  logic [NUM_PORTS-1:0]  in_downstream_ready;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FLIT_W-1:0]     out_send_north;
  logic [FLIT_W-1:0]     out_send_west;
  logic [FLIT_W-1:0]     out_send_south;
  logic [FLIT_W-1:0]     out_send_east;
  logic [FLIT_W-1:0]     out_send_local;
  logic [NUM_PORTS-1:0]  out_send_valid;
  logic [NUM_PORTS-1:0]  out_accept_ready;
  logic [NUM_PORTS-1:0]  out_uturn_error;

  logic [FLIT_W-1:0]  lane_buf [NUM_PORTS][LANE_DEPTH];
  int                 lane_fill [NUM_PORTS];
  logic [ROUTE_W-1:0] lane_route [NUM_PORTS];
  logic [COORD_W-1:0] here_x;
  logic [COORD_W-1:0] here_y;

  departure_t predicted_departures[$];

  int  mismatch_count  = 0;
  int  items_sent      = 0;
  int  flits_forwarded = 0;
  int  uturn_flags     = 0;
  int  flits_dropped   = 0;
  int  rx_hold_left    = 0;
  int  rx_burst_left   = 0;
  int  stuck_cycles    = 0;
  bit  idling_on       = 1'b1;

  mesh_xy_router_five_port_unit #(
    .BUFFER_DEPTH(LANE_DEPTH),
    .FLIT_WIDTH  (FLIT_W)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_flit_north      (in_flit_north),
    .in_flit_west       (in_flit_west),
    .in_flit_south      (in_flit_south),
    .in_flit_east       (in_flit_east),
    .in_flit_local      (in_flit_local),
    .in_arrive_valid    (in_arrive_valid),
    .in_downstream_ready(in_downstream_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_send_north     (out_send_north),
    .out_send_west      (out_send_west),
    .out_send_south     (out_send_south),
    .out_send_east      (out_send_east),
    .out_send_local     (out_send_local),
    .out_send_valid     (out_send_valid),
    .out_accept_ready   (out_accept_ready),
    .out_uturn_error    (out_uturn_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic string port_tag(input int p);
    case (p)
      PORT_N:  return "north";
      PORT_W:  return "west";
      PORT_S:  return "south";
      PORT_E:  return "east";
      default: return "local";
    endcase
  endfunction

  function automatic int arb_source(input int q, input int k);
    logic [4*ROUTE_W-1:0] order;
    case (q)
      PORT_N:  order = {PORT_L, PORT_E, PORT_S, PORT_W};
      PORT_W:  order = {PORT_L, PORT_E, PORT_S, PORT_N};
      PORT_S:  order = {PORT_L, PORT_E, PORT_W, PORT_N};
      PORT_E:  order = {PORT_L, PORT_S, PORT_W, PORT_N};
      default: order = {PORT_E, PORT_S, PORT_W, PORT_N};
    endcase
    return int'(order[k*ROUTE_W +: ROUTE_W]);
  endfunction

  function automatic logic [ROUTE_W-1:0] xy_direction(input logic [FLIT_W-1:0] f);
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    dest_x = f[DEST_X_LO +: COORD_W];
    dest_y = f[DEST_Y_LO +: COORD_W];
    if (dest_x != here_x) begin
      return (dest_x > here_x) ? PORT_E : PORT_W;
    end else if (dest_y != here_y) begin
      return (dest_y > here_y) ? PORT_S : PORT_N;
    end
    return PORT_L;
  endfunction

  task automatic forward_cycle(input link_cycle_t c, output departure_t d);
    int                 p;
    int                 q;
    int                 k;
    int                 i;
    int                 src;
    logic [ROUTE_W-1:0] dir;
    d = '0;
    for (p = 0; p < NUM_PORTS; p++) begin
      if (c.ready[p]) begin
        if (lane_fill[p] == 0) begin
          lane_route[p] = ROUTE_NONE;
        end else begin
          dir = xy_direction(lane_buf[p][0]);
          if (dir == p) begin
            d.uturn[p] = 1'b1;
          end else begin
            lane_route[p] = dir + 3'd1;
          end
        end
      end
    end
    for (q = 0; q < NUM_PORTS; q++) begin
      if (c.ready[q]) begin
        for (k = 0; k < 4; k++) begin
          src = arb_source(q, k);
          if (!d.send_valid[q] && lane_route[src] == q + 1 && lane_fill[src] > 0) begin
            d.send[q]       = lane_buf[src][0];
            d.send_valid[q] = 1'b1;
            for (i = 0; i < LANE_DEPTH - 1; i++) begin
              lane_buf[src][i] = lane_buf[src][i+1];
            end
            lane_fill[src]--;
          end
        end
      end
    end
    for (p = 0; p < NUM_PORTS; p++) begin
      if (c.arrive[p]) begin
        if (lane_fill[p] < LANE_DEPTH) begin
          lane_buf[p][lane_fill[p]] = c.flit[p];
          lane_fill[p]++;
        end else begin
          flits_dropped++;
        end
      end
      if (lane_fill[p] < LANE_DEPTH) begin
        d.accept_ready[p] = 1'b1;
      end
    end
    flits_forwarded += $countones(d.send_valid);
    uturn_flags     += $countones(d.uturn);
  endtask

  function automatic logic [FLIT_W-1:0] flit_to(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y);
    logic [FLIT_W-1:0] f;
    f = $urandom;
    f[DEST_X_LO +: COORD_W] = x;
    f[DEST_Y_LO +: COORD_W] = y;
    return f;
  endfunction

  function automatic logic [FLIT_W-1:0] well_formed_flit(input int p);
    logic [FLIT_W-1:0] f;
    do begin
      f = $urandom;
    end while (xy_direction(f) == p);
    return f;
  endfunction

  function automatic link_cycle_t random_crossing();
    link_cycle_t c;
    int          p;
    for (p = 0; p < NUM_PORTS; p++) begin
      c.flit[p] = ($urandom_range(0, 24) == 0) ? FLIT_W'($urandom) : well_formed_flit(p);
    end
    c.arrive = NUM_PORTS'($urandom);
    c.ready  = NUM_PORTS'($urandom);
    case ($urandom_range(0, 7))
      0: c.ready  = '1;
      1: c.arrive = '0;
      2: c.arrive = '1;
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_item(input link_cycle_t c);
    departure_t d;
    @(negedge clk);
    in_valid            = 1'b1;
    in_flit_north       = c.flit[PORT_N];
    in_flit_west        = c.flit[PORT_W];
    in_flit_south       = c.flit[PORT_S];
    in_flit_east        = c.flit[PORT_E];
    in_flit_local       = c.flit[PORT_L];
    in_arrive_valid     = c.arrive;
    in_downstream_ready = c.ready;
    do @(posedge clk); while (in_stall);
    forward_cycle(c, d);
    predicted_departures.insert(predicted_departures.size(), d);
    items_sent++;
  endtask

  task automatic send_flits(input logic [NUM_PORTS-1:0] arrive,
                            input logic [NUM_PORTS-1:0] ready,
                            input logic [FLIT_W-1:0] fn, fw, fs, fe, fl);
    link_cycle_t c;
    c.flit   = {fl, fe, fs, fw, fn};
    c.arrive = arrive;
    c.ready  = ready;
    send_item(c);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_all_departed();
    @(negedge clk);
    in_valid = 1'b0;
    while (predicted_departures.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_node(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    wait_all_departed();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = REG_NODE_X;
    cfg_wdata = x;
    @(negedge clk);
    cfg_index = REG_NODE_Y;
    cfg_wdata = y;
    @(negedge clk);
    cfg_we = 1'b0;
    here_x = x;
    here_y = y;
  endtask

  task automatic directed_routing();
    set_node(2'd1, 2'd2);
    // one flit per input port, routed only once every port turns ready
    send_flits('1, '0, flit_to(3, 0), flit_to(1, 3), flit_to(0, 1), flit_to(1, 0),
               flit_to(2, 2));
    repeat (2) send_flits('0, '1, '0, '0, '0, '0, '0);
    send_flits('1, '1, '0, '1, '0, '1, '0);
    repeat (2) send_flits('0, '1, '0, '0, '0, '0, '0);
    // four inputs contend for the east output
    send_flits(5'b10111, '0, flit_to(3, 1), flit_to(2, 0), flit_to(3, 3), '0,
               flit_to(2, 3));
    repeat (4) send_flits('0, '1, '0, '0, '0, '0, '0);
  endtask

  task automatic uturn_and_full_lane();
    send_flits('1, '0, flit_to(1, 0), flit_to(0, 2), flit_to(1, 3), flit_to(3, 2),
               flit_to(1, 2));
    repeat (2) send_flits('0, '1, '0, '0, '0, '0, '0);
    repeat (LANE_DEPTH + 1) begin
      send_flits(5'b00001, '0, flit_to(2, 3), '0, '0, '0, '0);
    end
    wait_all_departed();
  endtask

  task automatic backpressure_fill();
    link_cycle_t c;
    set_node(2'd2, 2'd1);
    rx_hold_left = 80;
    repeat (30) begin
      c = random_crossing();
      c.arrive = '1;
      send_item(c);
    end
    wait_all_departed();
  endtask

  task automatic random_traffic(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input int n);
    set_node(x, y);
    repeat (n) begin
      if (idling_on && $urandom_range(0, 9) == 0) begin
        pause_sender($urandom_range(1, 18));
      end
      send_item(random_crossing());
    end
  endtask

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall = 1'b1;
      rx_hold_left--;
    end else if (rx_burst_left > 0) begin
      out_stall = 1'b1;
      rx_burst_left--;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      out_stall     = 1'b1;
      rx_burst_left = $urandom_range(0, 17);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin : check_departures
    departure_t seen;
    departure_t want;
    int         p;
    if (rst_n && out_valid && !out_stall) begin
      seen.send         = {out_send_local, out_send_east, out_send_south,
                           out_send_west, out_send_north};
      seen.send_valid   = out_send_valid;
      seen.accept_ready = out_accept_ready;
      seen.uturn        = out_uturn_error;
      if (predicted_departures.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual send_valid %b",
                 $time, seen.send_valid);
        mismatch_count++;
      end else begin
        want = predicted_departures.pop_front();
        for (p = 0; p < NUM_PORTS; p++) begin
          if (seen.send[p] !== want.send[p]) begin
            $display("%0t: send_%s expected %h actual %h", $time, port_tag(p),
                     want.send[p], seen.send[p]);
            mismatch_count++;
          end
        end
        if (seen.send_valid !== want.send_valid) begin
          $display("%0t: send_valid expected %b actual %b", $time,
                   want.send_valid, seen.send_valid);
          mismatch_count++;
        end
        if (seen.accept_ready !== want.accept_ready) begin
          $display("%0t: accept_ready expected %b actual %b", $time,
                   want.accept_ready, seen.accept_ready);
          mismatch_count++;
        end
        if (seen.uturn !== want.uturn) begin
          $display("%0t: uturn_error expected %b actual %b", $time,
                   want.uturn, seen.uturn);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, stuck_cycles);
        $display("FAIL mesh_xy_router_five_port_unit");
        $finish;
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_NODE_X;
    cfg_wdata           = '0;
    in_valid            = 1'b0;
    in_flit_north       = '0;
    in_flit_west        = '0;
    in_flit_south       = '0;
    in_flit_east        = '0;
    in_flit_local       = '0;
    in_arrive_valid     = '0;
    in_downstream_ready = '0;
    here_x              = '0;
    here_y              = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      lane_fill[p]  = 0;
      lane_route[p] = ROUTE_NONE;
      for (int i = 0; i < LANE_DEPTH; i++) lane_buf[p][i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_routing();
    uturn_and_full_lane();
    backpressure_fill();
    random_traffic(2'd0, 2'd0, 100);
    random_traffic(2'd3, 2'd3, 100);
    random_traffic(2'd0, 2'd3, 100);
    random_traffic(2'd3, 2'd0, 100);
    random_traffic(2'd1, 2'd1, 100);
    idling_on = 1'b0;
    random_traffic(2'd2, 2'd2, 100);

    wait_all_departed();
    repeat (4) @(posedge clk);
    if (predicted_departures.size() != 0) begin
      $display("%0t: %0d items expected but never seen", $time,
               predicted_departures.size());
      mismatch_count += predicted_departures.size();
    end
    $display("Covered %0d crossbar cycles over 8 node positions with backpressure:",
             items_sent);
    $display("  %0d flits forwarded, %0d u-turns flagged, %0d arrivals dropped on full lanes",
             flits_forwarded, uturn_flags, flits_dropped);
    if (mismatch_count == 0) begin
      $display("PASS mesh_xy_router_five_port_unit");
    end else begin
      $display("FAIL mesh_xy_router_five_port_unit");
    end
    $finish;
  end

endmodule
